// File: src/reorderable_ordered_queue_defines.svh
// Assertion macros used by the queue RTL.
`ifndef REORDERABLE_ORDERED_QUEUE_DEFINES_SVH
`define REORDERABLE_ORDERED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROQ_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ROQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/roq_pkg.sv
`default_nettype none

package roq_pkg;

	// Sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TGT_W       = 8;
	localparam int CMP_W       = (CNT_W > TGT_W) ? CNT_W : TGT_W;
	localparam int ITEM_W      = 16;
	localparam int POS_W       = 5;

	// Command codes
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_MOVE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [1:0]        command;
		logic [ITEM_W-1:0] item_id;
		logic [TGT_W-1:0]  target_position;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ITEM_W-1:0] entry_id;
		logic [POS_W-1:0]  entry_position;
		logic              last;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_MOVE,
		CELL_ROTATE
	} cell_op_t;

	// Search key and list length, seen by every cell
	typedef struct packed {
		logic [ID_WIDTH-1:0] key;
		logic [CNT_W-1:0]    count;
	} lookup_t;

	// Per-cycle update order for the chain
	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] from_idx;
		logic [IDX_W-1:0] to_idx;
		logic [IDX_W-1:0] tail_idx;
		logic [CNT_W-1:0] count;
	} update_t;

endpackage

`default_nettype wire

// File: src/roq_cell.sv
`default_nettype none

module roq_cell (
	input  logic                         clk,
	input  logic [roq_pkg::IDX_W-1:0]    index,
	input  roq_pkg::lookup_t             lookup,
	input  roq_pkg::update_t             update,
	input  logic [roq_pkg::ID_WIDTH-1:0] prev_id,
	input  logic [roq_pkg::ID_WIDTH-1:0] next_id,
	input  logic [roq_pkg::ID_WIDTH-1:0] head_id,
	output logic [roq_pkg::ID_WIDTH-1:0] id_q,
	output logic                         match
);
	import roq_pkg::*;

	logic [CNT_W-1:0]    index_ext;
	logic [ID_WIDTH-1:0] id_d;

	assign index_ext = CNT_W'(index);

	// Only occupied slots take part in the search
	assign match = (id_q == lookup.key) && (index_ext < lookup.count);

	// Slot update: append at tail, shift for a move, rotate for a read
	always_comb begin
		id_d = id_q;
		case (update.op)
			CELL_APPEND: begin
				if (index_ext == update.count)
					id_d = lookup.key;
			end
			CELL_MOVE: begin
				if (index == update.to_idx)
					id_d = lookup.key;
				else if ((update.to_idx < update.from_idx) && (index > update.to_idx) &&
					(index <= update.from_idx))
					id_d = prev_id;
				else if ((update.to_idx > update.from_idx) && (index >= update.from_idx) &&
					(index < update.to_idx))
					id_d = next_id;
			end
			CELL_ROTATE: begin
				if (index == update.tail_idx)
					id_d = head_id;
				else if (index < update.tail_idx)
					id_d = next_id;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
	end

endmodule

`default_nettype wire

// File: src/roq_chain.sv
`default_nettype none

module roq_chain (
	input  logic                            clk,
	input  roq_pkg::lookup_t                lookup,
	input  roq_pkg::update_t                update,
	output logic [roq_pkg::ID_WIDTH-1:0]    head_id,
	output logic [roq_pkg::QUEUE_DEPTH-1:0] match,
	output logic                            found,
	output logic [roq_pkg::IDX_W-1:0]       from_idx
);
	import roq_pkg::*;

	logic [ID_WIDTH-1:0] cell_id [QUEUE_DEPTH];

	// Row of slots, each wired to its neighbours (itself at the ends) and the head
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_WIDTH-1:0] prev_w;
		logic [ID_WIDTH-1:0] next_w;

		if (i == 0) begin : g_first
			assign prev_w = cell_id[i];
		end else begin : g_prev
			assign prev_w = cell_id[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_w = cell_id[i];
		end else begin : g_next
			assign next_w = cell_id[i+1];
		end

		roq_cell u_cell (
			.clk     (clk),
			.index   (IDX_W'(i)),
			.lookup  (lookup),
			.update  (update),
			.prev_id (prev_w),
			.next_id (next_w),
			.head_id (cell_id[0]),
			.id_q    (cell_id[i]),
			.match   (match[i])
		);
	end

	assign head_id = cell_id[0];
	assign found   = |match;

	// Identifiers are unique, so at most one hit: OR the indices together
	always_comb begin
		from_idx = '0;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			if (match[k])
				from_idx = from_idx | IDX_W'(k);
		end
	end

endmodule

`default_nettype wire

// File: src/reorderable_ordered_queue.sv
// Channel   Dir  Handshake              Payload
// cmd       in   cmd_valid / cmd_stall  cmd_data (roq_pkg::cmd_t)
// res       out  res_valid / res_stall  res_data (roq_pkg::res_t)
//
// Add, move and unknown commands are accepted in S_IDLE and finished in S_EXEC, in
// which the slot row searches in parallel; a move shifts slots by one place.
// A non-empty read goes on from S_EXEC to S_READ; the row rotates one place per
// result and the head slot is emitted, so the rotation through the chain sets the rate.
// One command is in flight at a time; cmd_stall is high until it completes.
// Reset clears the list length and control; slot contents are not reset.
// A stalled result stays in the output register; execution waits for it.
`default_nettype none

`include "reorderable_ordered_queue_defines.svh"

module reorderable_ordered_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  roq_pkg::cmd_t   cmd_data,
	output logic            res_valid,
	input  logic            res_stall,
	output roq_pkg::res_t   res_data
);
	import roq_pkg::*;

	state_t                 state_q, state_d;
	cmd_t                   cmd_q;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [IDX_W-1:0]       rd_q, rd_d;
	res_t                   res_q, res_d;
	logic                   res_valid_q;
	logic                   res_load;
	logic                   cmd_accept;
	logic                   slot_free;

	lookup_t                lookup;
	update_t                update;
	logic [ID_WIDTH-1:0]    key;
	logic                   key_zero;
	logic [ID_WIDTH-1:0]    head_id;
	logic [QUEUE_DEPTH-1:0] match;
	logic                   found;
	logic [IDX_W-1:0]       from_idx;
	logic [IDX_W-1:0]       to_idx;
	logic [IDX_W-1:0]       tail_idx;
	logic [CMP_W-1:0]       tgt_ext, cnt_ext, to_c;
	logic [CNT_W-1:0]       pos_c;

	// Handshake
	assign cmd_stall  = (state_q != S_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign slot_free  = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;
	assign res_data   = res_q;

	// Key and move target
	assign key      = ID_WIDTH'(cmd_q.item_id);
	assign key_zero = (key == '0);
	assign lookup   = '{key: key, count: count_q};
	assign tgt_ext  = CMP_W'(cmd_q.target_position);
	assign cnt_ext  = CMP_W'(count_q);
	assign to_c     = (tgt_ext > cnt_ext) ? (cnt_ext - 1'b1) : (tgt_ext - 1'b1);
	assign to_idx   = IDX_W'(to_c);
	assign tail_idx = IDX_W'(count_q - 1'b1);
	assign pos_c    = CNT_W'(rd_q) + 1'b1;

	roq_chain u_chain (
		.clk      (clk),
		.lookup   (lookup),
		.update   (update),
		.head_id  (head_id),
		.match    (match),
		.found    (found),
		.from_idx (from_idx)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if ((cmd_q.command == CMD_READ) && (count_q != '0))
					state_d = S_READ;
				else if (slot_free)
					state_d = S_IDLE;
			end
			S_READ: begin
				if (slot_free && (rd_q == tail_idx))
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: result, slot update, counters
	always_comb begin
		res_load = 1'b0;
		res_d    = '{status: ST_OK, entry_id: '0, entry_position: '0, last: 1'b1};
		update   = '{op: CELL_HOLD, from_idx: from_idx, to_idx: to_idx,
			tail_idx: tail_idx, count: count_q};
		count_d  = count_q;
		rd_d     = rd_q;
		case (state_q)
			S_EXEC: begin
				rd_d = '0;
				if (slot_free) begin
					case (cmd_q.command)
						CMD_ADD: begin
							res_load = 1'b1;
							if (key_zero || found)
								res_d.status = ST_REJECT;
							else if (count_q == CNT_W'(QUEUE_DEPTH))
								res_d.status = ST_FULL;
							else begin
								update.op = CELL_APPEND;
								count_d   = count_q + 1'b1;
							end
						end
						CMD_MOVE: begin
							res_load = 1'b1;
							if ((cmd_q.target_position == '0) || key_zero || !found)
								res_d.status = ST_REJECT;
							else
								update.op = CELL_MOVE;
						end
						CMD_READ: begin
							// non-empty reads are emitted from S_READ
							if (count_q == '0) begin
								res_load     = 1'b1;
								res_d.status = ST_EMPTY;
							end
						end
						default: begin
							res_load     = 1'b1;
							res_d.status = ST_REJECT;
						end
					endcase
				end
			end
			S_READ: begin
				if (slot_free) begin
					res_load             = 1'b1;
					res_d.entry_id       = ITEM_W'(head_id);
					res_d.entry_position = POS_W'(pos_c);
					res_d.last           = (rd_q == tail_idx);
					update.op            = CELL_ROTATE;
					rd_d                 = rd_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_q        <= rd_d;
			res_valid_q <= res_load || (res_valid_q && res_stall);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_accept)
			cmd_q <= cmd_data;
		if (res_load)
			res_q <= res_d;
	end

	`ROQ_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "list length beyond depth")
	`ROQ_ASSERT_IMPLIES(a_ids_unique, clk, arst_n, 1'b1, $onehot0(match), "identifier held in two slots")
	`ROQ_ASSERT_NEXT(a_read_ends, clk, arst_n, (state_q == S_READ) && res_load && res_d.last, state_q == S_IDLE, "read did not end after last entry")
	`ROQ_ASSERT_IMPLIES(a_entry_valid, clk, arst_n, (state_q == S_READ) && res_load, (res_d.entry_id != '0) && (res_d.entry_position != '0), "read emitted an empty slot")

endmodule

`default_nettype wire
